[sv/eal_pkg.sv]
// Shared constants, codes and types for the event admission rate limiter.
// No dependencies; every other file imports this package.
package eal_pkg;

   // Sizing of the key table and category space
   localparam int DEDUP_ENTRIES  = 256;
   localparam int KEY_HASH_BITS  = 32;
   localparam int NUM_CATEGORIES = 11;

   // Field widths
   localparam int CAT_W      = 4;
   localparam int SEV_W      = 3;
   localparam int KEY_W      = 32;
   localparam int TIME_W     = 48;
   localparam int VERDICT_W  = 3;
   localparam int TOKENS_W   = 10;
   localparam int MASK_W     = 11;
   localparam int CAP_W      = 10;
   localparam int REFILL_W   = 16;
   localparam int WIN_W      = 16;
   localparam int WIN_REGS   = 3;
   localparam int WIN_PER_REG = 4;

   // Key split into table index and tag
   localparam int KEY_BITS  = (KEY_HASH_BITS < KEY_W) ? KEY_HASH_BITS : KEY_W;
   localparam int IDX_W     = $clog2(DEDUP_ENTRIES);
   localparam int TAG_W     = KEY_BITS - IDX_W;
   localparam int CAT_LIMIT = (NUM_CATEGORIES < MASK_W) ? NUM_CATEGORIES : MASK_W;

   // Dedup window in milliseconds
   localparam int MS_PER_S = 1000;
   localparam int WIN_MS_W = WIN_W + $clog2(MS_PER_S);

   // Token bucket fixed point: one token is TOKEN_UNIT units
   localparam int TOKEN_UNIT = 3600000;
   localparam int LEVEL_W    = 32;
   localparam int DT_W       = 32;
   localparam int ADD_W      = DT_W + REFILL_W;

   // Whole tokens: strip the power of two, then multiply by a reciprocal
   // of the odd part that is exact for every level below 2**LEVEL_W.
   localparam int UNIT_SHIFT = 7;
   localparam int UNIT_ODD   = TOKEN_UNIT >> UNIT_SHIFT;
   localparam int DIV_X_W    = LEVEL_W - UNIT_SHIFT;
   localparam int DIV_SHIFT  = DIV_X_W + $clog2(UNIT_ODD);
   localparam longint unsigned DIV_MAGIC =
      ((64'd1 << DIV_SHIFT) + 64'(UNIT_ODD) - 64'd1) / 64'(UNIT_ODD);
   localparam int MAGIC_W    = $clog2(DIV_MAGIC + 64'd1);
   localparam int PROD_W     = DIV_X_W + MAGIC_W;

   // Register port
   localparam int PDATA_W     = 64;
   localparam int PADDR_W     = 6;
   localparam int REG_SEL_LSB = 3;

   // Reset values
   localparam logic [MASK_W-1:0]  MASK_RESET   = 11'h3FD;
   localparam logic [CAP_W-1:0]   CAP_RESET    = 10'd10;
   localparam logic [REFILL_W-1:0] REFILL_RESET = 16'd60;
   localparam logic [PDATA_W-1:0] WIN_A_RESET  = 64'h0000_0000_0000_0000;
   localparam logic [PDATA_W-1:0] WIN_B_RESET  = 64'h012C_0000_0000_0000;
   localparam logic [PDATA_W-1:0] WIN_C_RESET  = 64'h0000_0258_0000_012C;
   localparam logic [LEVEL_W-1:0] LEVEL_RESET  = LEVEL_W'(CAP_RESET) * LEVEL_W'(TOKEN_UNIT);

   typedef enum logic [VERDICT_W-1:0] {
      VERDICT_SENT         = 3'd0,
      VERDICT_GLOBAL_OFF   = 3'd1,
      VERDICT_CATEGORY_OFF = 3'd2,
      VERDICT_LOW_SEVERITY = 3'd3,
      VERDICT_DUPLICATE    = 3'd4,
      VERDICT_RATE_LIMITED = 3'd5
   } verdict_type;

   typedef enum logic [2:0] {
      REG_NOTIFY_ENABLE    = 3'd0,
      REG_CATEGORY_MASK    = 3'd1,
      REG_SEVERITY_FLOOR   = 3'd2,
      REG_BUCKET_CAPACITY  = 3'd3,
      REG_REFILL_PER_HOUR  = 3'd4,
      REG_DEDUP_WINDOWS_A  = 3'd5,
      REG_DEDUP_WINDOWS_B  = 3'd6,
      REG_DEDUP_WINDOWS_C  = 3'd7
   } reg_index_type;

   typedef struct packed {
      logic                               notify_enable;
      logic [MASK_W-1:0]                  category_enable_mask;
      logic [SEV_W-1:0]                   severity_floor;
      logic [CAP_W-1:0]                   bucket_capacity;
      logic [REFILL_W-1:0]                refill_per_hour;
      logic [WIN_REGS-1:0][PDATA_W-1:0]   dedup_windows;
      logic [LEVEL_W-1:0]                 cap_units;
   } cfg_type;

   typedef struct packed {
      logic [TAG_W-1:0]  tag;
      logic [TIME_W-1:0] time_ms;
   } entry_type;

   typedef struct packed {
      verdict_type       verdict;
      logic [TIME_W-1:0] now_ms;
   } dedup_out_type;

   typedef struct packed {
      verdict_type        verdict;
      logic [LEVEL_W-1:0] level;
   } bkt_out_type;

endpackage

[sv/event_admission_rate_limiter_core.sv]
// Event admission limiter: takes one event per clock while the result side is ready
// and returns one verdict beat per event through stages s1 to s4 and the output
// register. The rate is set by the key table, a single memory read once when an
// event is accepted and written back at most once as it leaves s1; a write that lands
// on the edge of the next read is bypassed. Table valid bits are flip-flops cleared
// by reset, so the block is ready straight out of reset. Registers sit at byte
// address 8*i with 64-bit data; a bucket_capacity write refills the bucket.
// Depends on eal_pkg, eal_csr, eal_dedup, eal_bucket and eal_resp.
module event_admission_rate_limiter_core import eal_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [CAT_W-1:0]     req_category,
   input  logic [SEV_W-1:0]     req_severity,
   input  logic                 req_has_key,
   input  logic [KEY_W-1:0]     req_key_hash,
   input  logic [TIME_W-1:0]    req_now_ms,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [VERDICT_W-1:0] rsp_verdict,
   output logic                 rsp_send_now,
   output logic [TOKENS_W-1:0]  rsp_tokens_whole,
   input  logic                 csr_psel,
   input  logic                 csr_penable,
   input  logic                 csr_pwrite,
   input  logic [PADDR_W-1:0]   csr_paddr,
   input  logic [PDATA_W-1:0]   csr_pwdata,
   output logic [PDATA_W-1:0]   csr_prdata,
   output logic                 csr_pready
);

   cfg_type       cfg;
   logic          cap_write;
   logic          dd_valid, dd_ready;
   dedup_out_type dd_data;
   logic          bk_valid, bk_ready;
   bkt_out_type   bk_data;

   eal_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .psel      (csr_psel),
      .penable   (csr_penable),
      .pwrite    (csr_pwrite),
      .paddr     (csr_paddr),
      .pwdata    (csr_pwdata),
      .prdata    (csr_prdata),
      .pready    (csr_pready),
      .cfg       (cfg),
      .cap_write (cap_write)
   );

   eal_dedup u_dedup (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .category  (req_category),
      .severity  (req_severity),
      .has_key   (req_has_key),
      .key_hash  (req_key_hash),
      .now_ms    (req_now_ms),
      .out_valid (dd_valid),
      .out_ready (dd_ready),
      .out_data  (dd_data)
   );

   eal_bucket u_bucket (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .cap_write (cap_write),
      .in_valid  (dd_valid),
      .in_ready  (dd_ready),
      .in_data   (dd_data),
      .out_valid (bk_valid),
      .out_ready (bk_ready),
      .out_data  (bk_data)
   );

   eal_resp u_resp (
      .clock            (clock),
      .reset            (reset),
      .in_valid         (bk_valid),
      .in_ready         (bk_ready),
      .in_data          (bk_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_verdict      (rsp_verdict),
      .rsp_send_now     (rsp_send_now),
      .rsp_tokens_whole (rsp_tokens_whole)
   );

endmodule

[sv/eal_csr.sv]
// Configuration registers behind the APB-style port, with read-back.
// Depends on eal_pkg.
module eal_csr import eal_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [PADDR_W-1:0] paddr,
   input  logic [PDATA_W-1:0] pwdata,
   output logic [PDATA_W-1:0] prdata,
   output logic               pready,
   output cfg_type            cfg,
   output logic               cap_write
);

   cfg_type       cfg_ff, cfg_in;
   logic          cap_write_ff, cap_write_in;
   logic          wr_en;
   reg_index_type sel;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;
   assign sel    = reg_index_type'(paddr[PADDR_W-1:REG_SEL_LSB]);

   always_comb begin
      cfg_in       = cfg_ff;
      cap_write_in = 1'b0;
      if (wr_en) begin
         case (sel)
            REG_NOTIFY_ENABLE:   cfg_in.notify_enable = pwdata[0];
            REG_CATEGORY_MASK:   cfg_in.category_enable_mask = pwdata[MASK_W-1:0];
            REG_SEVERITY_FLOOR:  cfg_in.severity_floor = pwdata[SEV_W-1:0];
            REG_BUCKET_CAPACITY: begin
               cfg_in.bucket_capacity = pwdata[CAP_W-1:0];
               cfg_in.cap_units = LEVEL_W'(pwdata[CAP_W-1:0] * LEVEL_W'(TOKEN_UNIT));
               cap_write_in = 1'b1;
            end
            REG_REFILL_PER_HOUR: cfg_in.refill_per_hour = pwdata[REFILL_W-1:0];
            REG_DEDUP_WINDOWS_A: cfg_in.dedup_windows[0] = pwdata;
            REG_DEDUP_WINDOWS_B: cfg_in.dedup_windows[1] = pwdata;
            REG_DEDUP_WINDOWS_C: cfg_in.dedup_windows[2] = pwdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.notify_enable        <= 1'b0;
         cfg_ff.category_enable_mask <= MASK_RESET;
         cfg_ff.severity_floor       <= '0;
         cfg_ff.bucket_capacity      <= CAP_RESET;
         cfg_ff.refill_per_hour      <= REFILL_RESET;
         cfg_ff.dedup_windows[0]     <= WIN_A_RESET;
         cfg_ff.dedup_windows[1]     <= WIN_B_RESET;
         cfg_ff.dedup_windows[2]     <= WIN_C_RESET;
         cfg_ff.cap_units            <= LEVEL_RESET;
         cap_write_ff                <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         cap_write_ff <= cap_write_in;
      end
   end

   always_comb begin
      case (sel)
         REG_NOTIFY_ENABLE:   prdata = PDATA_W'(cfg_ff.notify_enable);
         REG_CATEGORY_MASK:   prdata = PDATA_W'(cfg_ff.category_enable_mask);
         REG_SEVERITY_FLOOR:  prdata = PDATA_W'(cfg_ff.severity_floor);
         REG_BUCKET_CAPACITY: prdata = PDATA_W'(cfg_ff.bucket_capacity);
         REG_REFILL_PER_HOUR: prdata = PDATA_W'(cfg_ff.refill_per_hour);
         REG_DEDUP_WINDOWS_A: prdata = cfg_ff.dedup_windows[0];
         REG_DEDUP_WINDOWS_B: prdata = cfg_ff.dedup_windows[1];
         REG_DEDUP_WINDOWS_C: prdata = cfg_ff.dedup_windows[2];
         default:             prdata = '0;
      endcase
   end

   assign cfg       = cfg_ff;
   assign cap_write = cap_write_ff;

endmodule

[sv/eal_dedup.sv]
// Filter checks and the direct-mapped key table: read at accept,
// compare and write back as the event leaves s1, with a bypass of the last write.
// Depends on eal_pkg.
module eal_dedup import eal_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  cfg_type           cfg,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic [CAT_W-1:0]  category,
   input  logic [SEV_W-1:0]  severity,
   input  logic              has_key,
   input  logic [KEY_W-1:0]  key_hash,
   input  logic [TIME_W-1:0] now_ms,
   output logic              out_valid,
   input  logic              out_ready,
   output dedup_out_type     out_data
);

   entry_type dedup_mem [DEDUP_ENTRIES];

   logic [DEDUP_ENTRIES-1:0] valid_ff, valid_in;
   logic                     s1_valid_ff, s1_valid_in;
   verdict_type              s1_verdict_ff;
   logic                     s1_keyed_ff;
   logic [IDX_W-1:0]         s1_idx_ff;
   logic [TAG_W-1:0]         s1_tag_ff;
   logic [TIME_W-1:0]        s1_now_ff;
   logic [WIN_MS_W-1:0]      s1_win_ms_ff;
   entry_type                rd_ff;
   logic [IDX_W-1:0]         fwd_idx_ff;
   entry_type                fwd_entry_ff;

   logic                     accept, advance, wr_en;
   logic [KEY_BITS-1:0]      key;
   logic [PDATA_W-1:0]       win_reg;
   logic [WIN_W-1:0]         win;
   logic [WIN_MS_W-1:0]      win_ms_in;
   logic [15:0]              mask_ext;
   verdict_type              verdict_in;
   entry_type                entry;
   logic                     hit, dup;
   logic [TIME_W-1:0]        age;

   assign in_ready = !s1_valid_ff || out_ready;
   assign accept   = in_valid && in_ready;
   assign advance  = s1_valid_ff && out_ready;
   assign key      = key_hash[KEY_BITS-1:0];
   assign mask_ext = 16'(cfg.category_enable_mask);

   // Window for the incoming category
   always_comb begin
      case (category[3:2])
         2'd0:    win_reg = cfg.dedup_windows[0];
         2'd1:    win_reg = cfg.dedup_windows[1];
         2'd2:    win_reg = cfg.dedup_windows[2];
         default: win_reg = cfg.dedup_windows[0];
      endcase
      win       = WIN_W'(win_reg >> {category[1:0], 4'b0000});
      win_ms_in = WIN_MS_W'(win * WIN_MS_W'(MS_PER_S));
   end

   // Early drop checks, in priority order
   always_comb begin
      if (!cfg.notify_enable)
         verdict_in = VERDICT_GLOBAL_OFF;
      else if (category >= CAT_W'(CAT_LIMIT) || !mask_ext[category])
         verdict_in = VERDICT_CATEGORY_OFF;
      else if (severity < cfg.severity_floor)
         verdict_in = VERDICT_LOW_SEVERITY;
      else
         verdict_in = VERDICT_SENT;
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_verdict_ff <= verdict_in;
         s1_keyed_ff   <= has_key && (win != '0);
         s1_idx_ff     <= key[IDX_W-1:0];
         s1_tag_ff     <= key[KEY_BITS-1:IDX_W];
         s1_now_ff     <= now_ms;
         s1_win_ms_ff  <= win_ms_in;
         rd_ff         <= dedup_mem[key[IDX_W-1:0]];
      end
      if (wr_en) begin
         dedup_mem[s1_idx_ff] <= '{tag: s1_tag_ff, time_ms: s1_now_ff};
         fwd_idx_ff           <= s1_idx_ff;
         fwd_entry_ff         <= '{tag: s1_tag_ff, time_ms: s1_now_ff};
      end
   end

   // The read issued on the edge of the previous write misses it: take the bypass
   always_comb begin
      entry = (fwd_idx_ff == s1_idx_ff) ? fwd_entry_ff : rd_ff;
      hit   = valid_ff[s1_idx_ff] && (entry.tag == s1_tag_ff);
      age   = (s1_now_ff >= entry.time_ms) ? s1_now_ff - entry.time_ms : '0;
      dup   = hit && (age < TIME_W'(s1_win_ms_ff));
      wr_en = advance && (s1_verdict_ff == VERDICT_SENT) && s1_keyed_ff && !dup;
   end

   always_comb begin
      valid_in = valid_ff;
      if (wr_en)
         valid_in[s1_idx_ff] = 1'b1;
      s1_valid_in = accept || (s1_valid_ff && !out_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         valid_ff    <= valid_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   assign out_valid        = s1_valid_ff;
   assign out_data.now_ms  = s1_now_ff;
   assign out_data.verdict = (s1_verdict_ff == VERDICT_SENT && s1_keyed_ff && dup) ?
                             VERDICT_DUPLICATE : s1_verdict_ff;

endmodule

[sv/eal_bucket.sv]
// Token bucket: elapsed time, refill product, cap and spend.
// Holds bucket level, last refill time and the clock-started flag. Depends on eal_pkg.
module eal_bucket import eal_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  cfg_type       cfg,
   input  logic          cap_write,
   input  logic          in_valid,
   output logic          in_ready,
   input  dedup_out_type in_data,
   output logic          out_valid,
   input  logic          out_ready,
   output bkt_out_type   out_data
);

   logic               s2_valid_ff, s2_valid_in;
   logic               s3_valid_ff, s3_valid_in;
   verdict_type        s2_verdict_ff, s3_verdict_ff;
   logic [DT_W-1:0]    s2_dt_ff;
   logic [ADD_W-1:0]   s3_add_ff;
   logic [LEVEL_W-1:0] level_ff, level_in;
   logic [TIME_W-1:0]  last_ms_ff, last_ms_in;
   logic               started_ff, started_in;

   logic               s2_load, s3_ready, s3_load, s3_done;
   logic [TIME_W-1:0]  dt;
   logic [DT_W-1:0]    dt_sat;
   logic [LEVEL_W:0]   sum;
   logic               full;
   logic [LEVEL_W-1:0] filled, level_after;
   verdict_type        verdict_after;

   assign s3_ready = !s3_valid_ff || out_ready;
   assign in_ready = !s2_valid_ff || s3_ready;
   assign s2_load  = in_valid && in_ready;
   assign s3_load  = s2_valid_ff && s3_ready;
   assign s3_done  = s3_valid_ff && out_ready;

   // Elapsed time since the last refill; saturate, any huge value fills the bucket unless the refill rate is zero
   always_comb begin
      dt = '0;
      if (started_ff && in_data.now_ms >= last_ms_ff)
         dt = in_data.now_ms - last_ms_ff;
      dt_sat = (|dt[TIME_W-1:DT_W]) ? '1 : dt[DT_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (s2_load) begin
         s2_verdict_ff <= in_data.verdict;
         s2_dt_ff      <= dt_sat;
      end
      if (s3_load) begin
         s3_verdict_ff <= s2_verdict_ff;
         s3_add_ff     <= s2_dt_ff * cfg.refill_per_hour;
      end
   end

   // Sent events: refill, cap, then spend one token if one is left; others keep the level
   always_comb begin
      sum           = {1'b0, level_ff} + {1'b0, s3_add_ff[LEVEL_W-1:0]};
      full          = (|s3_add_ff[ADD_W-1:LEVEL_W]) || (sum >= {1'b0, cfg.cap_units});
      filled        = full ? cfg.cap_units : sum[LEVEL_W-1:0];
      level_after   = level_ff;
      verdict_after = s3_verdict_ff;
      if (s3_verdict_ff == VERDICT_SENT) begin
         if (filled < LEVEL_W'(TOKEN_UNIT)) begin
            level_after   = filled;
            verdict_after = VERDICT_RATE_LIMITED;
         end else begin
            level_after = filled - LEVEL_W'(TOKEN_UNIT);
         end
      end
   end

   always_comb begin
      level_in   = level_ff;
      last_ms_in = last_ms_ff;
      started_in = started_ff;
      if (cap_write)
         level_in = cfg.cap_units;
      else if (s3_done)
         level_in = level_after;
      if (s2_load && in_data.verdict == VERDICT_SENT) begin
         last_ms_in = in_data.now_ms;
         started_in = 1'b1;
      end
      s2_valid_in = s2_load || (s2_valid_ff && !s3_ready);
      s3_valid_in = s3_load || (s3_valid_ff && !out_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff    <= LEVEL_RESET;
         last_ms_ff  <= '0;
         started_ff  <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         level_ff    <= level_in;
         last_ms_ff  <= last_ms_in;
         started_ff  <= started_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
      end
   end

   assign out_valid        = s3_valid_ff;
   assign out_data.verdict = verdict_after;
   assign out_data.level   = level_after;

endmodule

[sv/eal_resp.sv]
// Result stages: hold verdict and level, convert level to whole tokens
// by reciprocal multiplication into the output register. Depends on eal_pkg.
module eal_resp import eal_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  bkt_out_type         in_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [VERDICT_W-1:0] rsp_verdict,
   output logic                rsp_send_now,
   output logic [TOKENS_W-1:0] rsp_tokens_whole
);

   logic                 s4_valid_ff, s4_valid_in;
   bkt_out_type          s4_ff;
   logic                 out_valid_ff, out_valid_in;
   verdict_type          out_verdict_ff;
   logic [TOKENS_W-1:0]  out_tokens_ff;

   logic                 out_ready_int, s4_load, out_load;
   logic [PROD_W-1:0]    prod;

   assign out_ready_int = !out_valid_ff || rsp_ready;
   assign in_ready      = !s4_valid_ff || out_ready_int;
   assign s4_load       = in_valid && in_ready;
   assign out_load      = s4_valid_ff && out_ready_int;

   assign prod = PROD_W'(s4_ff.level[LEVEL_W-1:UNIT_SHIFT]) * PROD_W'(DIV_MAGIC);

   always_ff @(posedge clock) begin
      if (s4_load)
         s4_ff <= in_data;
      if (out_load) begin
         out_verdict_ff <= s4_ff.verdict;
         out_tokens_ff  <= prod[DIV_SHIFT +: TOKENS_W];
      end
   end

   always_comb begin
      s4_valid_in  = s4_load || (s4_valid_ff && !out_ready_int);
      out_valid_in = out_load || (out_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s4_valid_ff  <= s4_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_verdict      = out_verdict_ff;
   assign rsp_send_now     = (out_verdict_ff == VERDICT_SENT);
   assign rsp_tokens_whole = out_tokens_ff;

endmodule

[sv/eal_checker.sv]
// Port-level checks on the limiter, bound to the top level.
// Depends on eal_pkg.
module eal_checker import eal_pkg::*; (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic [VERDICT_W-1:0] rsp_verdict,
   input logic                 rsp_send_now,
   input logic [TOKENS_W-1:0]  rsp_tokens_whole
);

   logic [2:0] pending_ff, pending_in;

   // Count events accepted but not yet delivered
   always_comb begin
      pending_in = pending_ff;
      if (req_valid && req_ready && !(rsp_valid && rsp_ready))
         pending_in = pending_ff + 3'd1;
      else if (!(req_valid && req_ready) && rsp_valid && rsp_ready)
         pending_in = pending_ff - 3'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   a_send_matches_verdict: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_send_now == (rsp_verdict == VERDICT_SENT)))
      else $error("send_now disagrees with verdict");

   a_rate_limited_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_verdict == VERDICT_RATE_LIMITED |-> rsp_tokens_whole == '0)
      else $error("rate-limited beat reports tokens left");

   a_no_orphan_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != '0)
      else $error("result beat without an accepted event");

   a_stalled_beat_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_verdict)
                                  && $stable(rsp_tokens_whole))
      else $error("stalled result beat changed");

endmodule

bind event_admission_rate_limiter_core eal_checker u_eal_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_verdict      (rsp_verdict),
   .rsp_send_now     (rsp_send_now),
   .rsp_tokens_whole (rsp_tokens_whole)
);
